### src/sfoc_pkg.sv
package sfoc_pkg;

  localparam int DEF_NAME_TABLE_DEPTH = 32;
  localparam int DEF_NAME_ID_BITS     = 16;

  localparam int LEVEL_W   = 8;
  localparam int KIND_W    = 4;
  localparam int FIELD_ID_W = 16;
  localparam int STATUS_W  = 5;

  localparam logic [LEVEL_W-1:0] FAULT_LEVEL = 8'd4;
  localparam logic [LEVEL_W-1:0] CHILD_LEVEL = 8'd5;

  localparam logic [KIND_W-1:0] K_OTHER   = 4'd0;
  localparam logic [KIND_W-1:0] K_CODE    = 4'd1;
  localparam logic [KIND_W-1:0] K_REASON  = 4'd2;
  localparam logic [KIND_W-1:0] K_NODE    = 4'd3;
  localparam logic [KIND_W-1:0] K_ROLE    = 4'd4;
  localparam logic [KIND_W-1:0] K_DETAIL  = 4'd5;
  localparam logic [KIND_W-1:0] K_VALUE   = 4'd6;
  localparam logic [KIND_W-1:0] K_SUBCODE = 4'd7;
  localparam logic [KIND_W-1:0] K_TEXT    = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK             = 5'd0;
  localparam logic [STATUS_W-1:0] ST_MULTI_CODE     = 5'd1;
  localparam logic [STATUS_W-1:0] ST_MULTI_REASON   = 5'd2;
  localparam logic [STATUS_W-1:0] ST_ORDER          = 5'd3;
  localparam logic [STATUS_W-1:0] ST_CODE_NO_VALUE  = 5'd4;
  localparam logic [STATUS_W-1:0] ST_MULTI_NODE     = 5'd5;
  localparam logic [STATUS_W-1:0] ST_REASON_NO_TEXT = 5'd6;
  localparam logic [STATUS_W-1:0] ST_MULTI_ROLE     = 5'd7;
  localparam logic [STATUS_W-1:0] ST_ROLE_NO_TEXT   = 5'd8;
  localparam logic [STATUS_W-1:0] ST_MULTI_DETAIL   = 5'd9;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED    = 5'd10;
  localparam logic [STATUS_W-1:0] ST_MULTI_VALUE    = 5'd11;
  localparam logic [STATUS_W-1:0] ST_VALUE_FIRST    = 5'd12;
  localparam logic [STATUS_W-1:0] ST_MULTI_SUBCODE  = 5'd13;
  localparam logic [STATUS_W-1:0] ST_BAD_IN_CODE    = 5'd14;
  localparam logic [STATUS_W-1:0] ST_BAD_IN_REASON  = 5'd15;
  localparam logic [STATUS_W-1:0] ST_NO_PARENT      = 5'd16;
  localparam logic [STATUS_W-1:0] ST_BAD_IN_SUBCODE = 5'd17;
  localparam logic [STATUS_W-1:0] ST_UNTRACKED      = 5'd18;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL     = 5'd19;

  typedef struct packed {
    logic code_seen;
    logic reason_seen;
    logic node_seen;
    logic role_seen;
    logic detail_seen;
    logic code_value_seen;
    logic subcode_seen;
    logic subcode_value_seen;
    logic nested_subcode_seen;
    logic code_open;
    logic subcode_open;
    logic reason_open;
    logic detail_tracking;
  } flags_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                done;
    logic                need_scan;
    logic                add_name;
  } rule_res_t;

endpackage

### src/soap12_fault_order_checker.sv
// Sequence: an item is evaluated in S_EVAL and its result registered once the output is
//   free; a descendant of a Detail child walks the name table one entry a cycle in S_SCAN,
//   and S_DONE registers its result. One item at a time; the next item is taken the cycle
//   after the result is registered.
// Reset (rst, synchronous): clears all flags, the fill count and the handshake state.
//   Name table contents are left as they are; the fill count guards every read.
module soap12_fault_order_checker #(
  parameter int NAME_TABLE_DEPTH = sfoc_pkg::DEF_NAME_TABLE_DEPTH,
  parameter int NAME_ID_BITS     = sfoc_pkg::DEF_NAME_ID_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] level, [23:8] name_id, [39:24] parent_name_id
  input  logic [39:0] s_axis_tdata,
  // [3:0] element_kind, [7:4] parent_kind
  input  logic [7:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] status, [5] mandatory_done, [6] detail_mode, [7] zero
  output logic [7:0]  m_axis_tdata
);

  localparam int AddrW = (NAME_TABLE_DEPTH > 1) ? $clog2(NAME_TABLE_DEPTH) : 1;
  localparam int CntW  = $clog2(NAME_TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [sfoc_pkg::LEVEL_W-1:0]   level;
  logic [sfoc_pkg::KIND_W-1:0]    element_kind;
  logic [sfoc_pkg::KIND_W-1:0]    parent_kind;
  logic [NAME_ID_BITS-1:0]        name_id;
  logic [NAME_ID_BITS-1:0]        parent_name_id;
  logic [31:0]                    id_wide;
  logic [31:0]                    pid_wide;
  sfoc_pkg::flags_t               flags;
  sfoc_pkg::flags_t               flags_rule;
  sfoc_pkg::rule_res_t            res;
  logic [CntW-1:0]                count;
  logic [CntW-1:0]                idx;
  logic                           rd_pend;
  logic                           found;
  logic                           full;
  logic                           out_free;
  logic                           in_acc;
  logic                           wr_en;
  logic [NAME_ID_BITS-1:0]        rd_data;
  logic                           deliver;
  logic [sfoc_pkg::STATUS_W-1:0]  out_status;
  logic                           out_done;
  logic                           out_mode;
  logic                           more;

  assign id_wide  = {16'b0, s_axis_tdata[23:8]};
  assign pid_wide = {16'b0, s_axis_tdata[39:24]};

  assign full     = (count == CntW'(NAME_TABLE_DEPTH));
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign more     = (idx < count);

  sfoc_rules u_rules (
    .level        (level),
    .element_kind (element_kind),
    .parent_kind  (parent_kind),
    .full         (full),
    .flags        (flags),
    .flags_next   (flags_rule),
    .res          (res)
  );

  sfoc_ram #(
    .WIDTH (NAME_ID_BITS),
    .DEPTH (NAME_TABLE_DEPTH)
  ) u_names (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AddrW-1:0]),
    .wr_data (name_id),
    .rd_addr (idx[AddrW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    deliver    = 1'b0;
    wr_en      = 1'b0;
    out_status = res.status;
    out_done   = res.done;
    out_mode   = flags_rule.detail_tracking;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (res.need_scan) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          deliver    = 1'b1;
          wr_en      = res.add_name;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!more && !rd_pend) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        out_done = 1'b0;
        out_mode = flags.detail_tracking;
        if (!found) begin
          out_status = sfoc_pkg::ST_UNTRACKED;
        end else if (full) begin
          out_status = sfoc_pkg::ST_TABLE_FULL;
        end else begin
          out_status = sfoc_pkg::ST_OK;
        end
        if (out_free) begin
          deliver    = 1'b1;
          wr_en      = found && !full;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      flags         <= '0;
      count         <= '0;
      idx           <= '0;
      rd_pend       <= 1'b0;
      found         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        idx     <= '0;
        rd_pend <= 1'b0;
        found   <= 1'b0;
      end
      if (state == S_SCAN) begin
        // issue one read a cycle, compare the data from the previous one
        rd_pend <= more;
        if (more) begin
          idx <= idx + CntW'(1);
        end
        if (rd_pend && (rd_data == parent_name_id)) begin
          found <= 1'b1;
        end
      end
      if (deliver && (state == S_EVAL)) begin
        flags <= flags_rule;
      end
      if (wr_en) begin
        count <= count + CntW'(1);
      end
      if (deliver) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      level          <= s_axis_tdata[7:0];
      element_kind   <= s_axis_tuser[3:0];
      parent_kind    <= s_axis_tuser[7:4];
      name_id        <= id_wide[NAME_ID_BITS-1:0];
      parent_name_id <= pid_wide[NAME_ID_BITS-1:0];
    end
    if (deliver) begin
      m_axis_tdata <= {1'b0, out_mode, out_done, out_status};
    end
  end

endmodule

### src/sfoc_ram.sv
module sfoc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                    wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/sfoc_rules.sv
module sfoc_rules (
  input  logic [sfoc_pkg::LEVEL_W-1:0] level,
  input  logic [sfoc_pkg::KIND_W-1:0]  element_kind,
  input  logic [sfoc_pkg::KIND_W-1:0]  parent_kind,
  input  logic                         full,
  input  sfoc_pkg::flags_t             flags,
  output sfoc_pkg::flags_t             flags_next,
  output sfoc_pkg::rule_res_t          res
);

  always_comb begin
    flags_next = flags;
    res        = '0;
    res.status = sfoc_pkg::ST_OK;
    if (level == sfoc_pkg::FAULT_LEVEL) begin
      case (element_kind)
        sfoc_pkg::K_CODE: begin
          if (flags.code_seen) begin
            res.status = sfoc_pkg::ST_MULTI_CODE;
          end else begin
            flags_next.code_seen = 1'b1;
            flags_next.code_open = 1'b1;
          end
        end
        sfoc_pkg::K_REASON: begin
          if (flags.code_open || flags.subcode_open) begin
            res.status = sfoc_pkg::ST_CODE_NO_VALUE;
          end else if (!flags.code_seen) begin
            res.status = sfoc_pkg::ST_ORDER;
          end else if (flags.reason_seen) begin
            res.status = sfoc_pkg::ST_MULTI_REASON;
          end else begin
            flags_next.reason_seen = 1'b1;
            flags_next.reason_open = 1'b1;
          end
        end
        sfoc_pkg::K_NODE: begin
          if (flags.reason_open) begin
            res.status = sfoc_pkg::ST_REASON_NO_TEXT;
          end else if (!flags.reason_seen || flags.role_seen || flags.detail_seen) begin
            res.status = sfoc_pkg::ST_ORDER;
          end else if (flags.node_seen) begin
            res.status = sfoc_pkg::ST_MULTI_NODE;
          end else begin
            flags_next.node_seen = 1'b1;
          end
        end
        sfoc_pkg::K_ROLE: begin
          if (flags.reason_open) begin
            res.status = sfoc_pkg::ST_ROLE_NO_TEXT;
          end else if (!flags.reason_seen || flags.detail_seen) begin
            res.status = sfoc_pkg::ST_ORDER;
          end else if (flags.role_seen) begin
            res.status = sfoc_pkg::ST_MULTI_ROLE;
          end else begin
            flags_next.role_seen = 1'b1;
          end
        end
        sfoc_pkg::K_DETAIL: begin
          if (flags.reason_open) begin
            res.status = sfoc_pkg::ST_REASON_NO_TEXT;
          end else if (!flags.reason_seen) begin
            res.status = sfoc_pkg::ST_ORDER;
          end else if (flags.detail_seen) begin
            res.status = sfoc_pkg::ST_MULTI_DETAIL;
          end else begin
            flags_next.detail_seen = 1'b1;
          end
        end
        default: begin
          res.status = sfoc_pkg::ST_UNSUPPORTED;
        end
      endcase
    end else if (level == sfoc_pkg::CHILD_LEVEL) begin
      case (parent_kind)
        sfoc_pkg::K_CODE: begin
          if (element_kind == sfoc_pkg::K_VALUE) begin
            if (flags.code_value_seen) begin
              res.status = sfoc_pkg::ST_MULTI_VALUE;
            end else if (!flags.code_seen) begin
              res.status = sfoc_pkg::ST_NO_PARENT;
            end else begin
              flags_next.code_value_seen = 1'b1;
              flags_next.code_open       = 1'b0;
            end
          end else if (element_kind == sfoc_pkg::K_SUBCODE) begin
            if (flags.subcode_seen) begin
              res.status = sfoc_pkg::ST_MULTI_SUBCODE;
            end else if (!flags.code_value_seen) begin
              res.status = sfoc_pkg::ST_VALUE_FIRST;
            end else if (!flags.code_seen) begin
              res.status = sfoc_pkg::ST_NO_PARENT;
            end else begin
              flags_next.subcode_seen = 1'b1;
              flags_next.subcode_open = 1'b1;
            end
          end else begin
            res.status = sfoc_pkg::ST_BAD_IN_CODE;
          end
        end
        sfoc_pkg::K_REASON: begin
          if (element_kind != sfoc_pkg::K_TEXT) begin
            res.status = sfoc_pkg::ST_BAD_IN_REASON;
          end else if (!flags.reason_seen) begin
            res.status = sfoc_pkg::ST_NO_PARENT;
          end else begin
            flags_next.reason_open = 1'b0;
            res.done               = 1'b1;
          end
        end
        sfoc_pkg::K_DETAIL: begin
          // tracking starts even when the name is dropped
          flags_next.detail_tracking = 1'b1;
          if (full) begin
            res.status = sfoc_pkg::ST_TABLE_FULL;
          end else begin
            res.add_name = 1'b1;
          end
        end
        default: begin
          res.status = sfoc_pkg::ST_NO_PARENT;
        end
      endcase
    end else if (level > sfoc_pkg::CHILD_LEVEL) begin
      if (parent_kind == sfoc_pkg::K_SUBCODE) begin
        if (element_kind == sfoc_pkg::K_VALUE) begin
          if (flags.subcode_value_seen) begin
            res.status = sfoc_pkg::ST_MULTI_SUBCODE;
          end else if (!flags.code_seen || !flags.subcode_seen) begin
            res.status = sfoc_pkg::ST_NO_PARENT;
          end else begin
            flags_next.subcode_value_seen  = 1'b1;
            flags_next.nested_subcode_seen = 1'b0;
            flags_next.subcode_open        = 1'b0;
          end
        end else if (element_kind == sfoc_pkg::K_SUBCODE) begin
          if (!flags.subcode_value_seen) begin
            res.status = sfoc_pkg::ST_VALUE_FIRST;
          end else if (flags.nested_subcode_seen) begin
            res.status = sfoc_pkg::ST_MULTI_SUBCODE;
          end else if (!flags.code_seen || !flags.subcode_seen) begin
            res.status = sfoc_pkg::ST_NO_PARENT;
          end else begin
            flags_next.subcode_value_seen  = 1'b0;
            flags_next.nested_subcode_seen = 1'b1;
            flags_next.subcode_open        = 1'b1;
          end
        end else begin
          res.status = sfoc_pkg::ST_BAD_IN_SUBCODE;
        end
      end else if (flags.detail_tracking) begin
        res.need_scan = 1'b1;
      end
    end
  end

endmodule
